// File: rtl/qsu_pkg.sv
// shared types and constants of the quantized sample unpacker
`default_nettype none
package qsu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] sample_value;
    logic        last_of_run;
    logic        stream_done;
    logic [1:0]  status;
  } out_item_t;

  // one sample request handed from the front to the back
  typedef struct packed {
    logic [63:0] q;
    logic        lor;
    logic        done;
    logic [1:0]  status;
  } job_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_COUNT = 2'd1;
  localparam logic [1:0] ST_ZERO_FILL  = 2'd2;

  localparam logic [2:0] REG_BITS_PER_SAMPLE = 3'd0;
  localparam logic [2:0] REG_OUTPUT_FORMAT   = 3'd1;
  localparam logic [2:0] REG_SCALE_BITS      = 3'd2;
  localparam logic [2:0] REG_OFFSET_BITS     = 3'd3;
  localparam logic [2:0] REG_SAMPLE_COUNT    = 3'd4;

endpackage
`default_nettype wire

// File: rtl/qsu_front.sv
// front end: takes bytes, cuts bit fields and queues sample requests
`default_nettype none
module qsu_front #(
  parameter int MAX_FIELD_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire qsu_pkg::in_item_t in_data,
  input  wire logic [6:0]        bits_per_sample,
  input  wire logic [31:0]       sample_count,
  input  wire logic              bps_write,
  output logic                   push,
  output qsu_pkg::job_t          push_data,
  input  wire logic              q_full
);

  localparam int AW = $clog2(MAX_FIELD_BITS);
  localparam int CW = $clog2(MAX_FIELD_BITS + 1);
  localparam logic [6:0] MAX_W = 7'(MAX_FIELD_BITS);

  typedef enum logic [1:0] {S_IDLE, S_BITS, S_TAIL, S_FLUSH} state_t;

  state_t                    state;
  logic [MAX_FIELD_BITS-1:0] acc;
  logic [CW-1:0]             cnt;
  logic [31:0]               emitted;
  logic                      finished;
  logic [7:0]                byte_r;
  logic                      last_r;
  logic [2:0]                bit_idx;
  qsu_pkg::job_t             pend;
  logic                      pend_valid;

  logic [6:0]                wid;
  logic                      bit_in;
  logic [MAX_FIELD_BITS-1:0] acc_set;
  logic [CW-1:0]             cnt_inc;
  logic                      complete;
  logic                      can_emit;
  logic [31:0]               emitted_inc;
  logic                      fin_new;
  logic                      tail_emit;

  always_comb begin
    if (bits_per_sample == 7'd0) begin
      wid = 7'd1;
    end else if (bits_per_sample > MAX_W) begin
      wid = MAX_W;
    end else begin
      wid = bits_per_sample;
    end
    bit_in = byte_r[bit_idx];
    acc_set = acc;
    acc_set[cnt[AW-1:0]] = bit_in;
    cnt_inc = cnt + CW'(1);
    complete = 7'(cnt_inc) >= wid;
    can_emit = !pend_valid || !q_full;
    emitted_inc = emitted + 32'd1;
    fin_new = emitted_inc >= sample_count;
    tail_emit = last_r && !finished && (cnt != '0);
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    push = 1'b0;
    push_data = pend;
    push_data.lor = (state == S_FLUSH);
    case (state)
      S_BITS:  push = complete && pend_valid && !q_full;
      S_TAIL:  push = tail_emit && pend_valid && !q_full;
      S_FLUSH: push = pend_valid && !q_full;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc <= '0;
      cnt <= '0;
      emitted <= '0;
      finished <= 1'b0;
      pend_valid <= 1'b0;
      bit_idx <= '0;
    end else begin
      if (bps_write) begin
        acc <= '0;
        cnt <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_r <= in_data.data_byte;
            last_r <= in_data.last_byte;
            bit_idx <= 3'd7;
            if (sample_count == 32'd0) begin
              pend <= '{q: 64'd0, lor: 1'b0, done: 1'b0, status: qsu_pkg::ST_ZERO_COUNT};
              pend_valid <= 1'b1;
              state <= S_FLUSH;
            end else begin
              finished <= finished || (emitted >= sample_count);
              state <= S_BITS;
            end
          end
        end
        S_BITS: begin
          if (finished) begin
            state <= S_TAIL;
          end else if (complete) begin
            if (can_emit) begin
              pend <= '{q: 64'(acc_set), lor: 1'b0, done: fin_new, status: qsu_pkg::ST_OK};
              pend_valid <= 1'b1;
              emitted <= emitted_inc;
              finished <= fin_new;
              acc <= '0;
              cnt <= '0;
              bit_idx <= bit_idx - 3'd1;
              if (fin_new || bit_idx == 3'd0) begin
                state <= S_TAIL;
              end
            end
          end else begin
            acc <= acc_set;
            cnt <= cnt_inc;
            bit_idx <= bit_idx - 3'd1;
            if (bit_idx == 3'd0) begin
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          if (!tail_emit) begin
            state <= S_FLUSH;
          end else if (can_emit) begin
            // unfinished field, high bits taken as zero
            pend <= '{q: 64'(acc), lor: 1'b0, done: fin_new, status: qsu_pkg::ST_ZERO_FILL};
            pend_valid <= 1'b1;
            emitted <= emitted_inc;
            finished <= fin_new;
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid || !q_full) begin
            pend_valid <= 1'b0;
            if (last_r) begin
              acc <= '0;
              cnt <= '0;
              emitted <= '0;
              finished <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/qsu_queue.sv
// two-entry request queue between front and back
`default_nettype none
module qsu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire qsu_pkg::job_t push_data,
  input  wire logic          pop,
  output qsu_pkg::job_t      head,
  output logic               empty,
  output logic               full
);

  qsu_pkg::job_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign head = entry[rd_ptr];
  assign empty = (count == 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/qsu_back.sv
// back end: q / scale + offset in double, optional rounding to single
`default_nettype none
module qsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire qsu_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  input  wire logic          output_format,
  input  wire logic [63:0]   scale_bits,
  input  wire logic [63:0]   offset_bits,
  output logic               out_valid,
  input  wire logic          out_stall,
  output qsu_pkg::out_item_t out_data
);

  localparam logic [63:0] QNAN_D = 64'h7FF8000000000000;
  localparam logic [63:0] QNAN_S = 64'h000000007FC00000;

  typedef logic signed [13:0] exp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_QCVT, S_DIV, S_DIVN, S_RND1, S_RND2,
    S_ADD1, S_ADD2, S_ADD3, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_ADD, RET_FIN, RET_OUT} ret_t;

  state_t        state;
  qsu_pkg::job_t job;
  logic [63:0]   nrm;
  logic [6:0]    nexp;
  logic [52:0]   sm;
  logic [5:0]    sshift;
  logic [53:0]   rem;
  logic [55:0]   qt;
  logic [5:0]    dcnt;
  exp_t          eq;
  logic          r_sign;
  exp_t          r_exp;
  logic [63:0]   r_man;
  logic          r_st;
  logic          r_fmt;
  logic          r_den;
  ret_t          r_ret;
  logic [63:0]   dval;
  logic [63:0]   res;
  logic [65:0]   a66;
  logic [65:0]   b66;
  exp_t          ae;
  logic          asign;
  logic          asub;
  logic [65:0]   sum;

  // scale operand
  logic        sc_sign;
  logic [10:0] sc_exp;
  logic [51:0] sc_frac;
  logic        sc_nan, sc_inf, sc_zero;
  exp_t        sc_eff;

  // integer to double rounding
  logic [53:0] qr;
  logic [52:0] ma_new;
  logic [6:0]  ea_new;

  // divider step
  logic        ge;
  logic [53:0] rem_sub;

  // denormalizing shift
  exp_t        sh;
  logic [63:0] lost_mask;

  // final rounding
  logic [53:0] rd;
  logic        up_d;
  logic [24:0] rs;
  logic        up_s;
  exp_t        en_d;
  exp_t        en_s;
  logic [63:0] packed_d;
  logic [63:0] packed_s;

  // adder operands
  logic        d_sign, o_sign;
  logic [10:0] d_exp, o_exp;
  logic [51:0] d_frac, o_frac;
  logic        d_nan, o_nan, d_inf, o_inf, d_zero, o_zero;
  logic        swap;
  logic [52:0] big_m, small_m;
  logic [10:0] big_e, small_e;
  logic [10:0] ediff;
  logic [65:0] small_w;
  logic [65:0] small_sh;
  logic [65:0] small_lost;

  always_comb begin
    sc_sign = scale_bits[63];
    sc_exp = scale_bits[62:52];
    sc_frac = scale_bits[51:0];
    sc_nan = (sc_exp == 11'h7FF) && (sc_frac != '0);
    sc_inf = (sc_exp == 11'h7FF) && (sc_frac == '0);
    sc_zero = (sc_exp == 11'h000) && (sc_frac == '0);
    sc_eff = (sc_exp == 11'h000) ? exp_t'(1) : exp_t'({3'b000, sc_exp});

    qr = {1'b0, nrm[63:11]} + 54'(nrm[10] && ((nrm[9:0] != '0) || nrm[11]));
    ma_new = qr[53] ? {1'b1, 52'd0} : qr[52:0];
    ea_new = nexp + 7'(qr[53]);

    ge = rem >= {1'b0, sm};
    rem_sub = ge ? (rem - {1'b0, sm}) : rem;

    sh = exp_t'(1) - r_exp;
    lost_mask = ~(64'hFFFFFFFFFFFFFFFF << sh[5:0]);

    up_d = r_man[10] && ((r_man[9:0] != '0) || r_st || r_man[11]);
    rd = {1'b0, r_man[63:11]} + 54'(up_d);
    en_d = r_exp + exp_t'(rd[53]);
    if (r_den) begin
      packed_d = {r_sign, 10'd0, rd[52], rd[51:0]};
    end else if (en_d >= exp_t'(2047)) begin
      packed_d = {r_sign, 11'h7FF, 52'd0};
    end else begin
      packed_d = {r_sign, en_d[10:0], rd[51:0]};
    end

    up_s = r_man[39] && ((r_man[38:0] != '0) || r_st || r_man[40]);
    rs = {1'b0, r_man[63:40]} + 25'(up_s);
    en_s = r_exp + exp_t'(rs[24]);
    if (r_den) begin
      packed_s = {32'd0, r_sign, 7'd0, rs[23], rs[22:0]};
    end else if (en_s >= exp_t'(255)) begin
      packed_s = {32'd0, r_sign, 8'hFF, 23'd0};
    end else begin
      packed_s = {32'd0, r_sign, en_s[7:0], rs[22:0]};
    end

    d_sign = dval[63];
    d_exp = dval[62:52];
    d_frac = dval[51:0];
    o_sign = offset_bits[63];
    o_exp = offset_bits[62:52];
    o_frac = offset_bits[51:0];
    d_nan = (d_exp == 11'h7FF) && (d_frac != '0);
    o_nan = (o_exp == 11'h7FF) && (o_frac != '0);
    d_inf = (d_exp == 11'h7FF) && (d_frac == '0);
    o_inf = (o_exp == 11'h7FF) && (o_frac == '0);
    d_zero = (dval[62:0] == '0);
    o_zero = (offset_bits[62:0] == '0);
    swap = offset_bits[62:0] > dval[62:0];
    if (swap) begin
      big_m = {o_exp != '0, o_frac};
      big_e = (o_exp == '0) ? 11'd1 : o_exp;
      small_m = {d_exp != '0, d_frac};
      small_e = (d_exp == '0) ? 11'd1 : d_exp;
    end else begin
      big_m = {d_exp != '0, d_frac};
      big_e = (d_exp == '0) ? 11'd1 : d_exp;
      small_m = {o_exp != '0, o_frac};
      small_e = (o_exp == '0) ? 11'd1 : o_exp;
    end
    ediff = big_e - small_e;
    small_w = {1'b0, small_m, 12'd0};
    small_sh = small_w >> ediff;
    small_lost = small_w & ~(66'h3FFFFFFFFFFFFFFFF << ediff);
  end

  assign pop = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            job <= head;
            if (head.status == qsu_pkg::ST_ZERO_COUNT) begin
              res <= 64'd0;
              state <= S_DONE;
            end else begin
              nrm <= head.q;
              nexp <= 7'd63;
              sm <= {sc_exp != '0, sc_frac};
              sshift <= 6'd0;
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          // bring q and a subnormal divisor to a leading one, a byte or a bit a cycle
          if ((nrm != '0) && !nrm[63]) begin
            if (nrm[63:56] == '0) begin
              nrm <= nrm << 8;
              nexp <= nexp - 7'd8;
            end else begin
              nrm <= nrm << 1;
              nexp <= nexp - 7'd1;
            end
          end
          if ((sm != '0) && !sm[52]) begin
            if (sm[52:45] == '0) begin
              sm <= sm << 8;
              sshift <= sshift + 6'd8;
            end else begin
              sm <= sm << 1;
              sshift <= sshift + 6'd1;
            end
          end
          if (((nrm == '0) || nrm[63]) && ((sm == '0) || sm[52])) begin
            state <= S_QCVT;
          end
        end
        S_QCVT: begin
          if (sc_nan) begin
            dval <= QNAN_D;
            state <= S_ADD1;
          end else if (sc_inf) begin
            dval <= {sc_sign, 63'd0};
            state <= S_ADD1;
          end else if (sc_zero) begin
            dval <= (job.q == '0) ? QNAN_D : {sc_sign, 11'h7FF, 52'd0};
            state <= S_ADD1;
          end else if (job.q == '0) begin
            dval <= {sc_sign, 63'd0};
            state <= S_ADD1;
          end else begin
            rem <= {1'b0, ma_new};
            qt <= '0;
            dcnt <= 6'd0;
            eq <= exp_t'(ea_new) - sc_eff + exp_t'(sshift) + exp_t'(2046);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= {rem_sub[52:0], 1'b0};
          qt <= {qt[54:0], ge};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd55) begin
            state <= S_DIVN;
          end
        end
        S_DIVN: begin
          r_sign <= sc_sign;
          r_st <= (rem != '0);
          r_fmt <= 1'b1;
          r_ret <= RET_ADD;
          if (qt[55]) begin
            r_man <= {qt, 8'd0};
            r_exp <= eq;
          end else begin
            r_man <= {qt[54:0], 9'd0};
            r_exp <= eq - exp_t'(1);
          end
          state <= S_RND1;
        end
        S_RND1: begin
          r_den <= (r_exp < exp_t'(1));
          if (r_exp < exp_t'(1)) begin
            if (sh >= exp_t'(64)) begin
              r_man <= '0;
              r_st <= r_st || (r_man != '0);
            end else begin
              r_man <= r_man >> sh[5:0];
              r_st <= r_st || ((r_man & lost_mask) != '0);
            end
          end
          state <= S_RND2;
        end
        S_RND2: begin
          case (r_ret)
            RET_ADD: begin
              dval <= packed_d;
              state <= S_ADD1;
            end
            RET_FIN: begin
              res <= packed_d;
              state <= S_FIN;
            end
            RET_OUT: begin
              res <= r_fmt ? packed_d : packed_s;
              state <= S_DONE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_ADD1: begin
          state <= S_FIN;
          if (d_nan || o_nan || (d_inf && o_inf && (d_sign != o_sign))) begin
            res <= QNAN_D;
          end else if (d_inf) begin
            res <= dval;
          end else if (o_inf) begin
            res <= offset_bits;
          end else if (d_zero && o_zero) begin
            res <= {d_sign && o_sign, 63'd0};
          end else if (d_zero) begin
            res <= offset_bits;
          end else if (o_zero) begin
            res <= dval;
          end else begin
            a66 <= {1'b0, big_m, 12'd0};
            // lost bits jammed into the lowest position
            if (ediff >= 11'd66) begin
              b66 <= 66'd1;
            end else begin
              b66 <= small_sh | 66'(small_lost != '0);
            end
            ae <= exp_t'({3'b000, big_e}) + exp_t'(1);
            asign <= swap ? o_sign : d_sign;
            asub <= d_sign ^ o_sign;
            state <= S_ADD2;
          end
        end
        S_ADD2: begin
          sum <= asub ? (a66 - b66) : (a66 + b66);
          state <= S_ADD3;
        end
        S_ADD3: begin
          if (sum == '0) begin
            res <= 64'd0;
            state <= S_FIN;
          end else if (!sum[65]) begin
            if (sum[65:58] == '0) begin
              sum <= sum << 8;
              ae <= ae - exp_t'(8);
            end else begin
              sum <= sum << 1;
              ae <= ae - exp_t'(1);
            end
          end else begin
            r_man <= sum[65:2];
            r_st <= (sum[1:0] != '0);
            r_exp <= ae;
            r_sign <= asign;
            r_fmt <= 1'b1;
            r_ret <= RET_FIN;
            state <= S_RND1;
          end
        end
        S_FIN: begin
          if (output_format) begin
            if ((res[62:52] == 11'h7FF) && (res[51:0] != '0)) begin
              res <= QNAN_D;
            end
            state <= S_DONE;
          end else if (res[62:52] == 11'h7FF) begin
            res <= (res[51:0] != '0) ? QNAN_S : {32'd0, res[63], 8'hFF, 23'd0};
            state <= S_DONE;
          end else if (res[62:52] == 11'h000) begin
            // double subnormals are far below the single range
            res <= {32'd0, res[63], 31'd0};
            state <= S_DONE;
          end else begin
            r_man <= {1'b1, res[51:0], 11'd0};
            r_st <= 1'b0;
            r_exp <= exp_t'({3'b000, res[62:52]}) - exp_t'(896);
            r_sign <= res[63];
            r_fmt <= 1'b0;
            r_ret <= RET_OUT;
            state <= S_RND1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data <= '{sample_value: res, last_of_run: job.lor,
                          stream_done: job.done, status: job.status};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/quantized_sample_unpacker.sv
// top level of the quantized sample unpacker
// Packed bytes enter on the in channel (in_valid, in_stall, in_data), most
// significant bit first, and are cut into fields of bits_per_sample bits.
// Each field q leaves on the out channel as q / scale + offset in IEEE
// double, or rounded to single when output_format is 0.
// The front cuts fields one bit per cycle while the queue has room, takes
// no new byte until it is done with the last, and queues sample requests
// two deep. The back computes one sample at a time: integer conversion, a
// one-bit-per-cycle divider of 56 steps, the add and the roundings; the
// divider sets the throughput. Registers are written on cfg_write with
// cfg_index and cfg_data; the user must write them only while the block
// is idle, the block itself does not enforce it. Reset restores the
// register defaults and empties the stream state and the queue. A stall
// on the out channel holds the result register; the back then waits, the
// queue fills and in_stall rises.
`default_nettype none
module quantized_sample_unpacker #(
  parameter int MAX_FIELD_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire qsu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qsu_pkg::out_item_t      out_data,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [6:0]    bits_per_sample;
  logic          output_format;
  logic [63:0]   scale_bits;
  logic [63:0]   offset_bits;
  logic [31:0]   sample_count;
  logic          bps_write;
  logic          push;
  qsu_pkg::job_t push_data;
  logic          pop;
  qsu_pkg::job_t head;
  logic          empty;
  logic          full;

  assign bps_write = cfg_write && (cfg_index == qsu_pkg::REG_BITS_PER_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_sample <= 7'd8;
      output_format <= 1'b1;
      scale_bits <= 64'h3FF0000000000000;
      offset_bits <= 64'd0;
      sample_count <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        qsu_pkg::REG_BITS_PER_SAMPLE: bits_per_sample <= cfg_data[6:0];
        qsu_pkg::REG_OUTPUT_FORMAT:   output_format <= cfg_data[0];
        qsu_pkg::REG_SCALE_BITS:      scale_bits <= cfg_data;
        qsu_pkg::REG_OFFSET_BITS:     offset_bits <= cfg_data;
        qsu_pkg::REG_SAMPLE_COUNT:    sample_count <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  qsu_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .bits_per_sample (bits_per_sample),
    .sample_count    (sample_count),
    .bps_write       (bps_write),
    .push            (push),
    .push_data       (push_data),
    .q_full          (full)
  );

  qsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  qsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .output_format (output_format),
    .scale_bits    (scale_bits),
    .offset_bits   (offset_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

// File: dv/tb_quantized_sample_unpacker.sv
// self-checking testbench of the quantized sample unpacker
`default_nettype none
module tb_quantized_sample_unpacker;
  timeunit 1ns;
  timeprecision 1ps;
  import qsu_pkg::*;

  localparam int FIELD_MAX = 64;
  localparam bit [63:0] DBL_ONE  = 64'h3FF0000000000000;
  localparam bit [63:0] DBL_QNAN = 64'h7FF8000000000000;
  localparam bit [63:0] DBL_PINF = 64'h7FF0000000000000;
  localparam bit [63:0] DBL_NINF = 64'hFFF0000000000000;
  localparam bit [31:0] SGL_QNAN = 32'h7FC00000;

  // expected samples and the unpacking state that produces them
  class sample_board;
    bit [6:0]  width_reg;
    bit        fmt_double;
    bit [63:0] scale;
    bit [63:0] offset;
    bit [31:0] count;
    bit [63:0] acc;
    int        nbits;
    bit [31:0] emitted;
    bit        finished;
    out_item_t exp_samples[$];
    int        errors;
    int        matched;

    function new();
      width_reg = 7'd8; fmt_double = 1'b1; scale = DBL_ONE; offset = '0; count = '0;
      clear_stream();
      errors = 0; matched = 0;
    endfunction

    function void clear_stream();
      acc = '0; nbits = 0; emitted = '0; finished = 1'b0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] v);
      case (idx)
        REG_BITS_PER_SAMPLE: begin
          width_reg = v[6:0]; acc = '0; nbits = 0;
        end
        REG_OUTPUT_FORMAT: fmt_double = v[0];
        REG_SCALE_BITS:    scale = v;
        REG_OFFSET_BITS:   offset = v;
        REG_SAMPLE_COUNT:  count = v[31:0];
        default: ;
      endcase
    endfunction

    static function bit is_nan(bit [63:0] d);
      return d[62:52] == 11'h7FF && d[51:0] != 0;
    endfunction

    // exact unsigned integer to double, round to nearest even
    static function bit [63:0] int_to_dbl(bit [63:0] q);
      int p, sh;
      bit [63:0] kept, rem, half;
      if (q == 0) return '0;
      p = 63;
      while (!q[p]) p--;
      if (p <= 52) begin
        kept = q << (52 - p);
      end else begin
        sh = p - 52;
        kept = q >> sh;
        rem = q & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept++;
        if (kept[53]) begin
          kept = kept >> 1; p++;
        end
      end
      return {1'b0, 11'(p + 1023), kept[51:0]};
    endfunction

    // double to single, round to nearest even, subnormals and overflow included
    static function bit [31:0] dbl_to_sgl(bit [63:0] d);
      bit [31:0] sgn;
      bit [63:0] sig, kept, rem, half;
      int be, sh;
      if (is_nan(d)) return SGL_QNAN;
      sgn = {d[63], 31'd0};
      if (d[62:52] == 11'h7FF) return sgn | 32'h7F800000;
      if (d[62:52] == 0) return sgn;
      sig = {11'd0, 1'b1, d[51:0]};
      be = int'(d[62:52]) - 1023 + 127;
      sh = (be >= 1) ? 29 : 29 + (1 - be);
      if (sh > 60) return sgn;
      kept = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
      if (be < 1) return sgn | kept[31:0];
      if (kept[24]) begin
        kept = kept >> 1; be++;
      end
      if (be >= 255) return sgn | 32'h7F800000;
      return sgn | {1'b0, 8'(be), kept[22:0]};
    endfunction

    function bit [63:0] dequantize(bit [63:0] q);
      bit [63:0] quot, sum;
      if (scale[62:0] == 0)
        quot = (q == 0) ? DBL_QNAN : (scale[63] ? DBL_NINF : DBL_PINF);
      else
        quot = $realtobits($bitstoreal(int_to_dbl(q)) / $bitstoreal(scale));
      sum = $realtobits($bitstoreal(quot) + $bitstoreal(offset));
      if (!fmt_double) return {32'd0, dbl_to_sgl(sum)};
      return is_nan(sum) ? DBL_QNAN : sum;
    endfunction

    function void push_sample(bit [63:0] q, bit [1:0] st);
      out_item_t s;
      emitted++;
      if (emitted >= count) finished = 1'b1;
      s.sample_value = dequantize(q);
      s.last_of_run = 1'b0;
      s.stream_done = finished;
      s.status = st;
      exp_samples.push_back(s);
    endfunction

    // work out the samples that one accepted request causes
    function void note_request(in_item_t it);
      int w, n0, i;
      out_item_t s;
      n0 = exp_samples.size();
      w = (width_reg == 0) ? 1 : (width_reg > FIELD_MAX) ? FIELD_MAX : int'(width_reg);
      if (count == 0) begin
        s.sample_value = '0; s.last_of_run = 1'b1; s.stream_done = 1'b0;
        s.status = ST_ZERO_COUNT;
        exp_samples.push_back(s);
        if (it.last_byte) clear_stream();
        return;
      end
      if (emitted >= count) finished = 1'b1;
      if (!finished) begin
        for (i = 7; i >= 0; i--) begin
          acc[nbits] = it.data_byte[i];
          nbits++;
          if (nbits >= w) begin
            push_sample(acc, ST_OK);
            acc = '0; nbits = 0;
            if (finished) break;
          end
        end
        if (it.last_byte && !finished && nbits > 0) push_sample(acc, ST_ZERO_FILL);
      end
      if (exp_samples.size() > n0) exp_samples[exp_samples.size() - 1].last_of_run = 1'b1;
      if (it.last_byte) clear_stream();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (exp_samples.size() == 0) begin
        report($sformatf("unexpected sample %h", got));
        return;
      end
      e = exp_samples.pop_front();
      if (got.sample_value !== e.sample_value)
        report($sformatf("sample_value %h, expected %h", got.sample_value, e.sample_value));
      else if (got.last_of_run !== e.last_of_run)
        report($sformatf("last_of_run %b, expected %b", got.last_of_run, e.last_of_run));
      else if (got.stream_done !== e.stream_done)
        report($sformatf("stream_done %b, expected %b", got.stream_done, e.stream_done));
      else if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      else
        matched++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  sample_board board = new();
  bit calm = 1'b0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int streams_run = 0;

  always #6 clk = ~clk;

  quantized_sample_unpacker u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random stall bursts plus the long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_tag) begin
      hold_seen = hold_tag;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) board.check_result(out_data);

  task write_reg(bit [2:0] idx, bit [63:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task setup(bit [6:0] w, bit fmt, bit [63:0] sc, bit [63:0] off, bit [31:0] cnt);
    write_reg(REG_BITS_PER_SAMPLE, 64'(w));
    write_reg(REG_OUTPUT_FORMAT, 64'(fmt));
    write_reg(REG_SCALE_BITS, sc);
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_SAMPLE_COUNT, 64'(cnt));
  endtask

  task send_byte(bit [7:0] b, bit last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_request(it);
    bytes_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain every expected sample, then let the front finish bytes without results
  task wait_idle();
    stop_sending();
    while (board.exp_samples.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function bit [63:0] rand_dbl();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return DBL_ONE;
      2: return 64'h0;
      3: return 64'h8000000000000000;
      4: return $urandom_range(0, 1) ? DBL_PINF : DBL_NINF;
      5: return {1'b0, 11'h7FF, 20'd0, $urandom | 32'd1};
      6: return {1'($urandom), 11'($urandom_range(1, 2046)), 52'd0};
      7: return 64'h406FE00000000000;
      default: return {1'($urandom), 11'($urandom_range(983, 1063)), 20'($urandom), $urandom};
    endcase
  endfunction

  task run_stream(int nb, bit close);
    for (int i = 0; i < nb; i++) send_byte(8'($urandom), close && i == nb - 1);
    streams_run++;
  endtask

  initial begin
    bit [6:0] w;
    bit [31:0] cnt;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sample count right after reset
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    // first bit read lands in the lsb; bytes after the last owed sample are dropped
    setup(7'd8, 1'b1, DBL_ONE, 64'h0, 32'd4);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_idle();
    // one-bit fields in single format, negative offset
    setup(7'd1, 1'b0, 64'h4000000000000000, 64'hBFF8000000000000, 32'd10);
    send_byte(8'hA5, 1'b1);
    wait_idle();
    // full-width fields, divide by +0, zero-filled tail
    setup(7'd64, 1'b1, 64'h0, 64'h0, 32'd2);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_idle();
    // 0 / -0 gives NaN, offset all ones
    setup(7'd127, 1'b0, 64'h8000000000000000, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF);
    send_byte(8'h00, 1'b1);
    wait_idle();
    // width 0 acts as 1, single overflow and a double subnormal flushed to single zero
    setup(7'd0, 1'b0, 64'h0170000000000000, 64'h0, 32'd3);
    send_byte(8'hE0, 1'b1);
    wait_idle();
    write_reg(REG_SCALE_BITS, 64'h7FE0000000000000);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    // count lowered mid-stream, then a count and a width write before the last byte
    setup(7'd12, 1'b1, DBL_ONE, 64'h3FF0000000000000, 32'd5);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 64'd2);
    send_byte(8'h78, 1'b0);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 64'd6);
    write_reg(REG_BITS_PER_SAMPLE, 64'd12);
    send_byte(8'h9A, 1'b1);
    wait_idle();

    while (bytes_sent < 430) begin
      if (bytes_sent > 390) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: w = 7'($urandom_range(65, 127));
        1: w = 7'd0;
        2: w = 7'($urandom_range(1, 4));
        default: w = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 19))
        0, 1: cnt = 32'd0;
        2: cnt = 32'hFFFFFFFF;
        default: cnt = 32'($urandom_range(1, 24));
      endcase
      setup(w, 1'($urandom), rand_dbl(), rand_dbl(), cnt);
      if (streams_run == 4) begin
        // long receiver hold-off while bytes keep coming
        write_reg(REG_BITS_PER_SAMPLE, 64'd1);
        write_reg(REG_SAMPLE_COUNT, 64'd1000);
        hold_tag++;
        run_stream(20, 1'b1);
      end else begin
        run_stream($urandom_range(1, 12), $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0) run_stream($urandom_range(1, 6), 1'b1);
      end
      wait_idle();
    end

    repeat (300) @(posedge clk);
    foreach (board.exp_samples[i]) board.report("expected sample never arrived");
    $display("ran %0d byte requests in %0d streams; %0d samples matched",
             bytes_sent, streams_run, board.matched);
    $display("covered zero count, zero fill, width clamping, zero divisor, NaN and single range");
    if (board.errors == 0)
      $display("** quantized_sample_unpacker: PASSED **");
    else
      $display("** quantized_sample_unpacker: FAILED **");
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout at %0t", $realtime);
    $display("** quantized_sample_unpacker: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// File: quantized_sample_unpacker.f
rtl/qsu_pkg.sv
rtl/qsu_front.sv
rtl/qsu_queue.sv
rtl/qsu_back.sv
rtl/quantized_sample_unpacker.sv
dv/tb_quantized_sample_unpacker.sv
